// ===== hw/rtl/isl_pkg.sv =====
// ----------------------------------------------------------------------------
// isl_pkg: shared types and constants for the indexed shift list
// Operation codes, cell actions, field widths and default sizes.
// ----------------------------------------------------------------------------
package isl_pkg;

  localparam int DefCapacity  = 16;
  localparam int DefWordWidth = 32;

  localparam int OpcodeW   = 4;
  localparam int PositionW = 5;
  localparam int DataW     = 32;
  localparam int RunW      = 5;
  localparam int FillW     = 5;

  localparam int InDataW  = 48;
  localparam int OutDataW = 40;

  localparam logic [OpcodeW-1:0] OP_PUSH   = 4'd0;
  localparam logic [OpcodeW-1:0] OP_POP    = 4'd1;
  localparam logic [OpcodeW-1:0] OP_PEEK   = 4'd2;
  localparam logic [OpcodeW-1:0] OP_SET    = 4'd3;
  localparam logic [OpcodeW-1:0] OP_GET    = 4'd4;
  localparam logic [OpcodeW-1:0] OP_TAKE   = 4'd5;
  localparam logic [OpcodeW-1:0] OP_INSERT = 4'd6;
  localparam logic [OpcodeW-1:0] OP_REMOVE = 4'd7;
  localparam logic [OpcodeW-1:0] OP_ERASE  = 4'd8;
  localparam logic [OpcodeW-1:0] OP_CLEAR  = 4'd9;

  // what every cell does in one cycle, relative to the broadcast address
  typedef enum logic [2:0] {
    ACT_NONE,   // hold
    ACT_WRITE,  // cell at address loads the input word
    ACT_ZERO,   // cell at address clears
    ACT_INS,    // cells above address take lower neighbor, address loads word
    ACT_DEL,    // cells at and above address take upper neighbor
    ACT_CLR     // every cell clears
  } act_e;

endpackage

// ===== hw/rtl/indexed_shift_list_unit.sv =====
// ----------------------------------------------------------------------------
// indexed_shift_list_unit: fixed-capacity ordered list of words
// A row of slot cells with a fill count, driven by one operation per item.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one operation per item: tuser holds the opcode, tdata
//   holds position, data_in and run_length. m_axis returns one result per
//   item: ok, data_out, fill_count, is_empty and is_full.
//   Push, pop, peek, set, get, take, insert, remove, clear and an erase of
//   at most one element finish in the cycle the item is accepted; the result
//   is valid on m_axis the next cycle, and a new item can be taken every
//   cycle. An erase of n > 1 elements shifts the cell row by one slot per
//   cycle, its last shift waiting for a free output register, and holds
//   s_axis_tready low meanwhile. The result sits in an output register,
//   so the next item is accepted while it waits, as long as m_axis_tready
//   takes it in the same cycle or the register is empty. A stalled
//   receiver holds the result and holds s_axis_tready low.
//   Reset clears every slot and the fill count; the block is ready
//   as soon as reset is released.
// ----------------------------------------------------------------------------
module indexed_shift_list_unit #(
  parameter int CAPACITY   = isl_pkg::DefCapacity,
  parameter int WORD_WIDTH = isl_pkg::DefWordWidth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // [4:0] position, [36:5] data_in, [41:37] run_length, [47:42] zero
  input  logic [isl_pkg::InDataW-1:0]  s_axis_tdata,
  // [3:0] opcode
  input  logic [isl_pkg::OpcodeW-1:0]  s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [0] ok, [32:1] data_out, [37:33] fill_count, [38] is_empty, [39] is_full
  output logic [isl_pkg::OutDataW-1:0] m_axis_tdata
);
  import isl_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > PositionW) ? CW : PositionW;
  localparam logic [CW-1:0] CapC = CW'(CAPACITY);

  logic [CW-1:0] count_d, count_q;
  logic [CW-1:0] rem_d, rem_q;
  logic [CW-1:0] pos_d, pos_q;
  logic          busy_d, busy_q;

  logic                 out_valid_q;
  logic                 out_ok_q, out_empty_q, out_full_q;
  logic [DataW-1:0]     out_data_q;
  logic [FillW-1:0]     out_fill_q;

  logic [OpcodeW-1:0]   opcode;
  logic [PositionW-1:0] position;
  logic [DataW-1:0]     data_in;
  logic [RunW-1:0]      run_length;

  logic          accept, out_free, emit, ok, use_rd;
  act_e          act;
  logic [CW-1:0] addr;
  logic [PW-1:0] pos_ext, cnt_ext, avail, run_ext, run_eff;
  logic          pos_lt_cnt;

  logic [WORD_WIDTH-1:0] din;
  logic [WORD_WIDTH-1:0] slot  [CAPACITY];
  logic [WORD_WIDTH-1:0] rd    [CAPACITY];
  logic [WORD_WIDTH-1:0] rd_word;

  assign position   = s_axis_tdata[4:0];
  assign data_in    = s_axis_tdata[36:5];
  assign run_length = s_axis_tdata[41:37];
  assign opcode     = s_axis_tuser;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !busy_q && out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign din        = WORD_WIDTH'(data_in);
  assign pos_ext    = PW'(position);
  assign cnt_ext    = PW'(count_q);
  assign run_ext    = PW'(run_length);
  assign pos_lt_cnt = (pos_ext < cnt_ext);
  assign avail      = cnt_ext - pos_ext;
  assign run_eff    = (run_ext > avail) ? avail : run_ext;

  always_comb begin
    act     = ACT_NONE;
    addr    = '0;
    ok      = 1'b0;
    use_rd  = 1'b0;
    emit    = 1'b0;
    count_d = count_q;
    busy_d  = busy_q;
    rem_d   = rem_q;
    pos_d   = pos_q;
    if (busy_q) begin
      // erase run in progress: one slot per cycle, the last once the output is free
      addr = pos_q;
      if (rem_q > CW'(1)) begin
        act     = ACT_DEL;
        count_d = CW'(count_q - 1'b1);
        rem_d   = CW'(rem_q - 1'b1);
      end else if (out_free) begin
        act     = ACT_DEL;
        count_d = CW'(count_q - 1'b1);
        rem_d   = '0;
        busy_d  = 1'b0;
        emit    = 1'b1;
        ok      = 1'b1;
      end
    end else if (accept) begin
      emit = 1'b1;
      unique case (opcode)
        OP_PUSH: begin
          if (count_q < CapC) begin
            act     = ACT_WRITE;
            addr    = count_q;
            count_d = CW'(count_q + 1'b1);
            ok      = 1'b1;
          end
        end
        OP_POP: begin
          if (count_q != '0) begin
            act     = ACT_ZERO;
            addr    = CW'(count_q - 1'b1);
            count_d = CW'(count_q - 1'b1);
            use_rd  = 1'b1;
            ok      = 1'b1;
          end
        end
        OP_PEEK: begin
          if (count_q != '0) begin
            addr   = CW'(count_q - 1'b1);
            use_rd = 1'b1;
            ok     = 1'b1;
          end
        end
        OP_SET: begin
          if (pos_lt_cnt) begin
            act  = ACT_WRITE;
            addr = CW'(pos_ext);
            ok   = 1'b1;
          end
        end
        OP_GET: begin
          if (pos_lt_cnt) begin
            addr   = CW'(pos_ext);
            use_rd = 1'b1;
            ok     = 1'b1;
          end
        end
        OP_TAKE: begin
          if (pos_lt_cnt) begin
            act    = ACT_ZERO;
            addr   = CW'(pos_ext);
            use_rd = 1'b1;
            ok     = 1'b1;
          end
        end
        OP_INSERT: begin
          if (pos_ext <= cnt_ext && count_q < CapC) begin
            act     = ACT_INS;
            addr    = CW'(pos_ext);
            count_d = CW'(count_q + 1'b1);
            ok      = 1'b1;
          end
        end
        OP_REMOVE: begin
          if (pos_lt_cnt) begin
            act     = ACT_DEL;
            addr    = CW'(pos_ext);
            count_d = CW'(count_q - 1'b1);
            use_rd  = 1'b1;
            ok      = 1'b1;
          end
        end
        OP_ERASE: begin
          if (pos_lt_cnt) begin
            ok   = 1'b1;
            addr = CW'(pos_ext);
            if (run_eff != '0) begin
              act     = ACT_DEL;
              count_d = CW'(count_q - 1'b1);
            end
            if (run_eff > PW'(1)) begin
              busy_d = 1'b1;
              rem_d  = CW'(run_eff - 1'b1);
              pos_d  = CW'(pos_ext);
              emit   = 1'b0;
            end
          end
        end
        OP_CLEAR: begin
          act     = ACT_CLR;
          count_d = '0;
          ok      = 1'b1;
        end
        default: ok = 1'b0;
      endcase
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [WORD_WIDTH-1:0] lower, upper;
    if (i == 0) begin : g_first
      assign lower = '0;
    end else begin : g_low
      assign lower = slot[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign upper = '0;
    end else begin : g_up
      assign upper = slot[i+1];
    end
    isl_cell #(
      .WORD_WIDTH (WORD_WIDTH),
      .ADDR_W     (CW),
      .INDEX      (i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .act_i   (act),
      .addr_i  (addr),
      .din_i   (din),
      .lower_i (lower),
      .upper_i (upper),
      .slot_o  (slot[i]),
      .rd_o    (rd[i])
    );
  end

  always_comb begin
    rd_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_word = rd_word | rd[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      rem_q   <= '0;
      pos_q   <= '0;
      busy_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      rem_q   <= rem_d;
      pos_q   <= pos_d;
      busy_q  <= busy_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_ok_q    <= ok;
      out_data_q  <= (ok && use_rd) ? DataW'(rd_word) : '0;
      out_fill_q  <= FillW'(count_d);
      out_empty_q <= (count_d == '0);
      out_full_q  <= (count_d == CapC);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_full_q, out_empty_q, out_fill_q, out_data_q, out_ok_q};

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapC)
    else $error("fill count above capacity");

  a_busy_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (rem_q != '0 && pos_q < count_q))
    else $error("erase run state out of range");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && opcode == OP_CLEAR) |=> (count_q == '0 && m_axis_tvalid))
    else $error("clear did not empty the list");

  a_busy_holds_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && rem_q > CW'(1)) |-> !emit)
    else $error("result emitted mid erase run");

endmodule

// ===== hw/rtl/isl_cell.sv =====
// ----------------------------------------------------------------------------
// isl_cell: one slot of the indexed shift list
// Holds one word; loads, clears or shifts from a neighbor per broadcast action.
// ----------------------------------------------------------------------------
module isl_cell #(
  parameter int WORD_WIDTH = isl_pkg::DefWordWidth,
  parameter int ADDR_W     = 5,
  parameter int INDEX      = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  isl_pkg::act_e         act_i,
  input  logic [ADDR_W-1:0]     addr_i,
  input  logic [WORD_WIDTH-1:0] din_i,
  input  logic [WORD_WIDTH-1:0] lower_i,
  input  logic [WORD_WIDTH-1:0] upper_i,
  output logic [WORD_WIDTH-1:0] slot_o,
  output logic [WORD_WIDTH-1:0] rd_o
);
  import isl_pkg::*;

  localparam logic [ADDR_W-1:0] Idx = ADDR_W'(INDEX);

  logic [WORD_WIDTH-1:0] slot_d, slot_q;
  logic                  hit, above;

  assign hit   = (addr_i == Idx);
  assign above = (Idx > addr_i);

  always_comb begin
    slot_d = slot_q;
    unique case (act_i)
      ACT_NONE:  slot_d = slot_q;
      ACT_WRITE: if (hit) slot_d = din_i;
      ACT_ZERO:  if (hit) slot_d = '0;
      ACT_INS: begin
        if (hit) begin
          slot_d = din_i;
        end else if (above) begin
          slot_d = lower_i;
        end
      end
      ACT_DEL:   if (hit || above) slot_d = upper_i;
      ACT_CLR:   slot_d = '0;
      default:   slot_d = slot_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else begin
      slot_q <= slot_d;
    end
  end

  assign slot_o = slot_q;
  assign rd_o   = hit ? slot_q : '0;

endmodule
